// ===== src/sxfr_pkg.sv =====
// shared types and constants for the sync/length/xor frame receiver
// no dependencies; imported by every module of the block except the ram
package sxfr_pkg;

  // request commands
  localparam logic [1:0] CMD_RX      = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0] SYNC_RESET  = 8'hA0;
  localparam logic [7:0] MIN_LENGTH  = 8'd2;
  localparam int         STORE_DEPTH_DEF = 35;
  localparam int         FIFO_DEPTH  = 4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       frame_ready;
    logic       byte_taken;
    logic [7:0] read_data;
    logic [7:0] frame_length;
  } out_item_t;

  // front to back: one classified request, read data still pending
  typedef struct packed {
    logic       frame_ready;
    logic       byte_taken;
    logic       is_read;
    logic [7:0] frame_length;
  } fb_item_t;

endpackage

// ===== src/sxfr_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module sxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sxfr_front.sv =====
// front end: accepts requests, runs the frame hunt, issues store writes and reads
// depends on sxfr_pkg
module sxfr_front #(
  parameter int STORE_DEPTH = sxfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  sxfr_pkg::in_item_t             in_item,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  output logic                           mem_we,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_raddr,
  output logic                           fb_valid,
  output sxfr_pkg::fb_item_t             fb_item
);
  import sxfr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic          ready_r, ready_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    sync_r;
  logic          taken;
  logic          is_read;
  logic          len_ok;
  logic [7:0]    b;

  assign b = in_item.rx_byte;
  // length must leave room for the checksum inside the store
  assign len_ok = (b >= MIN_LENGTH) && ((9'(b) + 9'd1) < 9'(STORE_DEPTH));

  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    ready_nxt = ready_r;
    len_nxt   = len_r;
    taken     = 1'b0;
    is_read   = 1'b0;
    mem_we    = 1'b0;
    if (in_fire) begin
      case (in_item.cmd)
        CMD_RX: begin
          if (!ready_r) begin
            taken  = 1'b1;
            mem_we = 1'b1;
            if (pos_r == '0) begin
              xor_nxt = '0;
              if (b == sync_r) begin
                xor_nxt = b;
                pos_nxt = AW'(1);
              end
            end else if (pos_r == AW'(1)) begin
              len_nxt = b;
              if (len_ok) begin
                xor_nxt = xor_r ^ b;
                pos_nxt = AW'(2);
              end else begin
                xor_nxt = '0;
                pos_nxt = '0;
              end
            end else if (8'(pos_r) <= len_r) begin
              xor_nxt = xor_r ^ b;
              pos_nxt = pos_r + AW'(1);
            end else begin
              // checksum byte
              if (xor_r == b) begin
                ready_nxt = 1'b1;
              end
              pos_nxt = '0;
            end
          end
        end
        CMD_RELEASE: ready_nxt = 1'b0;
        CMD_READ:    is_read = {1'b0, in_item.read_index} < 7'(STORE_DEPTH);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      xor_r   <= '0;
      ready_r <= 1'b0;
      sync_r  <= SYNC_RESET;
    end else begin
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
      ready_r <= ready_nxt;
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
    end
    len_r <= len_nxt;
  end

  assign mem_waddr = pos_r;
  assign mem_wdata = b;
  assign mem_raddr = in_item.read_index[AW-1:0];

  assign fb_valid             = in_fire;
  assign fb_item.frame_ready  = ready_nxt;
  assign fb_item.byte_taken   = taken;
  assign fb_item.is_read      = is_read;
  assign fb_item.frame_length = ready_nxt ? len_nxt : 8'd0;

  // a locked receiver always restarts the hunt from the sync byte
  a_ready_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> pos_r == '0)
    else $error("ready flag set with hunt in progress");

  // no store write while a frame is locked
  a_locked_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> !mem_we)
    else $error("store written while frame locked");

  // the hunt position never leaves the store
  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < STORE_DEPTH)
    else $error("hunt position beyond the store");

endmodule

// ===== src/sxfr_back.sv =====
// back end: merges store read data into results and queues them for the consumer
// depends on sxfr_pkg
module sxfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fb_valid,
  input  sxfr_pkg::fb_item_t   fb_item,
  input  logic [7:0]           mem_rdata,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output sxfr_pkg::out_item_t  out_item
);
  import sxfr_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic      s1_valid_r;
  fb_item_t  s1_r;
  out_item_t fifo_r [FIFO_DEPTH];
  out_item_t push_item;
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop_fire;

  // the registered store read lands together with its request in the read stage
  assign push_item.frame_ready  = s1_r.frame_ready;
  assign push_item.byte_taken   = s1_r.byte_taken;
  assign push_item.read_data    = s1_r.is_read ? mem_rdata : 8'd0;
  assign push_item.frame_length = s1_r.frame_length;

  assign pop_fire = out_pop && (cnt_r != '0);
  assign cnt_nxt  = cnt_r + CW'(s1_valid_r) - CW'(pop_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wptr_r     <= '0;
      rptr_r     <= '0;
      cnt_r      <= '0;
    end else begin
      s1_valid_r <= fb_valid;
      cnt_r      <= cnt_nxt;
      if (s1_valid_r) begin
        wptr_r <= (wptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop_fire) begin
        rptr_r <= (rptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
    end
    s1_r <= fb_item;
    if (s1_valid_r) begin
      fifo_r[wptr_r] <= push_item;
    end
  end

  // room is reserved for the request still in the read stage
  assign in_full   = (cnt_r + CW'(s1_valid_r)) >= CW'(FIFO_DEPTH);
  assign out_empty = (cnt_r == '0);
  assign out_item  = fifo_r[rptr_r];

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) + 32'(s1_valid_r)) <= FIFO_DEPTH)
    else $error("result queue overrun");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> cnt_r != '0)
    else $error("pushed result lost");

  a_full_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |=> !s1_valid_r)
    else $error("request entered while full");

endmodule

// ===== src/sync_length_xor_frame_receiver_core.sv =====
// top level of the sync/length/xor frame receiver
// depends on sxfr_pkg, sxfr_front, sxfr_ram, sxfr_back
//
//  channel   handshake              payload
//  request   push / full            in_item   (cmd, rx_byte, read_index)
//  result    empty / pop            out_item  (frame_ready, byte_taken, read_data,
//                                              frame_length)
//  config    cfg_we                 cfg_wdata (sync byte)
//
// one request per cycle sustained while full is low; the frame hunt is a combinational
// update in the front end, so every command kind issues back to back
// a result passes through the registered store read and then the result queue write
// before it shows on the result ports
// full rises when the result queue and the read stage together hold four entries;
// the consumer stalling with pop low only backs up through full
// synchronous active-low reset clears the hunt, the ready flag, the queue and
// sets the sync byte to 0xA0; the byte store needs no clearing
module sync_length_xor_frame_receiver_core #(
  parameter int STORE_DEPTH = sxfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request side
  input  logic                push,
  output logic                full,
  input  sxfr_pkg::in_item_t  in_item,
  // result side
  output logic                empty,
  input  logic                pop,
  output sxfr_pkg::out_item_t out_item,
  // configuration
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import sxfr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic          in_fire;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          fb_valid;
  fb_item_t      fb_item;

  assign in_fire = push && !full;

  // hunt state machine and store access
  sxfr_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .fb_valid  (fb_valid),
    .fb_item   (fb_item)
  );

  // frame byte store
  sxfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read merge and result queue
  sxfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fb_valid  (fb_valid),
    .fb_item   (fb_item),
    .mem_rdata (mem_rdata),
    .in_full   (full),
    .out_empty (empty),
    .out_pop   (pop),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sxfr_frame_checker.sv =====
// checker for the sync/length/xor frame receiver: watches the request, result and
// config ports, predicts every result and compares it with what the block returns
// depends on sxfr_pkg
module sxfr_frame_checker #(
  parameter int STORE_DEPTH = sxfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic                   full,
  input  sxfr_pkg::in_item_t     in_item,
  input  logic                   empty,
  input  logic                   pop,
  input  sxfr_pkg::out_item_t    out_item,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output logic                   hunt_at_start,
  output logic                   frame_locked,
  output logic [STORE_DEPTH-1:0] store_written
);
  import sxfr_pkg::*;

  logic [7:0] byte_store [STORE_DEPTH];
  logic [5:0] hunt_pos;
  logic [7:0] hunt_xor;
  logic       ready_q;
  logic [7:0] sync_q;
  out_item_t  want;
  out_item_t  expected_results [$];

  // one received byte through the frame hunt
  function automatic void hunt_byte(logic [7:0] b);
    if (hunt_pos >= STORE_DEPTH) begin
      hunt_pos = '0;
      hunt_xor = '0;
      return;
    end
    byte_store[hunt_pos] = b;
    store_written[hunt_pos] = 1'b1;
    if (hunt_pos == 0) begin
      hunt_xor = '0;
      if (b == sync_q) begin
        hunt_xor = b;
        hunt_pos = 6'd1;
      end
    end else if (hunt_pos == 1) begin
      if (b >= MIN_LENGTH && int'(b) + 1 < STORE_DEPTH) begin
        hunt_xor = hunt_xor ^ b;
        hunt_pos = 6'd2;
      end else begin
        hunt_pos = '0;
        hunt_xor = '0;
      end
    end else if (int'(hunt_pos) < int'(byte_store[1]) + 1) begin
      hunt_xor = hunt_xor ^ b;
      hunt_pos = hunt_pos + 6'd1;
    end else begin
      if (hunt_xor == b) ready_q = 1'b1;
      hunt_pos = '0;
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    res = '0;
    case (req.cmd)
      CMD_RX: begin
        if (!ready_q) begin
          hunt_byte(req.rx_byte);
          res.byte_taken = 1'b1;
        end
      end
      CMD_RELEASE: ready_q = 1'b0;
      CMD_READ: begin
        if (req.read_index < STORE_DEPTH) res.read_data = byte_store[req.read_index];
      end
      default: ;
    endcase
    res.frame_ready = ready_q;
    res.frame_length = ready_q ? byte_store[1] : 8'd0;
    return res;
  endfunction

  function automatic void check_field(string field, logic [7:0] exp_val, logic [7:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0h, got %0h", field, exp_val, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      hunt_pos = '0;
      hunt_xor = '0;
      ready_q = 1'b0;
      sync_q = SYNC_RESET;
      store_written = '0;
      fail_count = 0;
    end else begin
      if (cfg_we) sync_q = cfg_wdata;
      // results leave only after their request has passed the read stage and the queue, so check before predicting
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: %p", out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_ready", 8'(want.frame_ready), 8'(out_item.frame_ready));
          check_field("byte_taken", 8'(want.byte_taken), 8'(out_item.byte_taken));
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("frame_length", want.frame_length, out_item.frame_length);
        end
      end
      if (push && !full) expected_results.push_back(predict_result(in_item));
    end
    pending = expected_results.size();
    hunt_at_start = (hunt_pos == 0);
    frame_locked = ready_q;
  end

endmodule

// ===== tb/tb_sync_length_xor_frame_receiver_core.sv =====
// testbench top for sync_length_xor_frame_receiver_core: drives requests, config
// writes and result pops with random gaps, and prints the verdict
// depends on sxfr_pkg, sxfr_frame_checker and the block itself
module tb_sync_length_xor_frame_receiver_core;
  import sxfr_pkg::*;

  localparam int STORE_DEPTH = STORE_DEPTH_DEF;
  // cycles with no handshake on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // command code the block must treat as a no-op
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum int {
    FLAW_NONE,
    FLAW_SHORT_LEN,
    FLAW_LONG_LEN,
    FLAW_BAD_SUM,
    FLAW_TRUNCATED
  } frame_flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int                     fail_count;
  int                     pending;
  logic                   hunt_at_start;
  logic                   frame_locked;
  logic [STORE_DEPTH-1:0] store_written;

  // current sync byte as last written, used to build frames
  logic [7:0] cur_sync = SYNC_RESET;
  int         snd_idle_pct = 30;
  int         rcv_idle_pct = 87;
  int         taken_count;
  int         idle_cycles = 0;

  sync_length_xor_frame_receiver_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sxfr_frame_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_item      (in_item),
    .empty        (empty),
    .pop          (pop),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .hunt_at_start(hunt_at_start),
    .frame_locked (frame_locked),
    .store_written(store_written)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // consumer side: pop decided fresh every cycle from the current idle rate
  always @(negedge clk) begin
    pop <= ($urandom_range(99, 0) >= rcv_idle_pct);
  end

  // hang detection: any accepted request or result restarts the count
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one request: optional random gap, then hold push until the block takes it
  // called right after an acceptance edge, so each negedge sees one push update
  task automatic send_request(logic [1:0] cmd, logic [7:0] data, logic [5:0] idx);
    in_item_t req;
    req.cmd = cmd;
    req.rx_byte = data;
    req.read_index = idx;
    // bytes dropped while a frame is locked do not count toward the item budget
    if (!(cmd == CMD_RX && frame_locked)) taken_count++;
    while ($urandom_range(99, 0) < snd_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_rx(logic [7:0] b);
    send_request(CMD_RX, b, 6'($urandom));
  endtask

  // read a store entry that has been written, or an index past the end of the store
  task automatic read_stored();
    logic [5:0] idx;
    if (store_written != '0 && $urandom_range(99, 0) < 70) begin
      do idx = 6'($urandom_range(STORE_DEPTH - 1, 0)); while (!store_written[idx]);
    end else begin
      idx = 6'($urandom_range(63, STORE_DEPTH));
    end
    send_request(CMD_READ, 8'($urandom), idx);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results(int extra);
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // new sync byte, written only with the block idle
  task automatic set_sync(logic [7:0] value);
    drain_results(4);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_sync = value;
  endtask

  // bring the hunt back to position 0 with no frame locked, so a frame can start
  task automatic resync_hunt();
    logic [7:0] b;
    while (frame_locked || !hunt_at_start) begin
      if (frame_locked) begin
        send_request(CMD_RELEASE, 8'($urandom), 6'($urandom));
      end else begin
        do b = 8'($urandom); while (b == cur_sync);
        send_rx(b);
      end
    end
  endtask

  // a frame with random payload; most lengths small, some at the store limit
  task automatic send_frame(frame_flaw_t flaw);
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned r;
    int unsigned body;
    r = $urandom_range(99, 0);
    if (r < 10) len = 8'(STORE_DEPTH - 2);
    else if (r < 30) len = 8'($urandom_range(STORE_DEPTH - 2, 10));
    else len = 8'($urandom_range(9, MIN_LENGTH));
    send_rx(cur_sync);
    if (flaw == FLAW_SHORT_LEN) begin
      send_rx(8'($urandom_range(MIN_LENGTH - 1, 0)));
      return;
    end
    if (flaw == FLAW_LONG_LEN) begin
      // any length whose checksum slot falls outside the store
      send_rx(8'($urandom_range(255, STORE_DEPTH - 1)));
      return;
    end
    send_rx(len);
    sum = cur_sync ^ len;
    // payload fills positions 2..len; a truncated frame stops short
    body = (flaw == FLAW_TRUNCATED) ? $urandom_range(len - 2, 0) : len - 1;
    repeat (body) begin
      b = 8'($urandom);
      sum = sum ^ b;
      send_rx(b);
    end
    if (flaw == FLAW_TRUNCATED) return;
    if (flaw == FLAW_BAD_SUM) sum = sum ^ (8'h01 << $urandom_range(7, 0));
    send_rx(sum);
  endtask

  // random traffic: mostly clean frames, with reads, releases, noise and broken frames
  task automatic random_traffic(int items);
    int unsigned r;
    taken_count = 0;
    while (taken_count < items) begin
      r = $urandom_range(99, 0);
      if (r < 50) begin
        resync_hunt();
        send_frame(FLAW_NONE);
        if ($urandom_range(1, 0)) read_stored();
      end else if (r < 62) begin
        resync_hunt();
        send_frame(frame_flaw_t'($urandom_range(FLAW_TRUNCATED, FLAW_SHORT_LEN)));
      end else if (r < 77) begin
        read_stored();
      end else if (r < 85) begin
        send_request(CMD_RELEASE, 8'($urandom), 6'($urandom));
      end else if (r < 93) begin
        // stray byte, may land mid-frame or be dropped while locked
        send_rx(8'($urandom));
      end else if (r < 97) begin
        send_request(CMD_SPARE, 8'($urandom), 6'($urandom));
      end else begin
        // sender holds off until the result queue has fully drained
        drain_results(0);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sender idles 30%, receiver 87%, sync byte at its reset value
    send_request(CMD_READ, 8'hFF, 6'd63);               // read past the store, all ones
    send_request(CMD_READ, 8'h00, 6'(STORE_DEPTH));     // first index past the store
    send_request(CMD_SPARE, 8'hFF, 6'd63);              // unused command
    send_request(CMD_RELEASE, 8'h00, 6'd0);             // release with nothing locked
    send_rx(8'h00);                                     // bad sync, still stored at 0
    send_request(CMD_READ, 8'h00, 6'd0);
    send_rx(SYNC_RESET);
    send_rx(MIN_LENGTH - 8'd1);                         // short length
    send_rx(SYNC_RESET);
    send_rx(8'hFF);                                     // overlong length
    send_rx(SYNC_RESET);
    send_rx(8'(STORE_DEPTH - 1));                       // first length that overruns
    send_rx(SYNC_RESET);                                // shortest good frame
    send_rx(MIN_LENGTH);
    send_rx(8'h5A);
    send_rx(SYNC_RESET ^ MIN_LENGTH ^ 8'h5A);
    send_rx(8'hFF);                                     // dropped while locked
    send_request(CMD_READ, 8'h00, 6'd3);
    send_request(CMD_READ, 8'h00, 6'd1);
    send_request(CMD_RELEASE, 8'h00, 6'd0);
    send_rx(SYNC_RESET);                                // frame with a wrong checksum
    send_rx(MIN_LENGTH);
    send_rx(8'h00);
    send_rx(SYNC_RESET ^ MIN_LENGTH ^ 8'h80);
    send_rx(8'hFF);                                     // stray byte at position 0

    random_traffic(150);

    // swap the idle rates, highest sync byte
    set_sync(8'hFF);
    snd_idle_pct = 87;
    rcv_idle_pct = 30;
    random_traffic(150);

    // no idling from here on, lowest then random sync byte
    set_sync(8'h00);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_traffic(75);
    set_sync(8'($urandom));
    random_traffic(75);

    // let everything drain, then keep waiting for any stray result before the verdict
    drain_results(10);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
